@@ design/assert_macros.svh @@
// Assertion macros used by the filter core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ design/whwf_pkg.sv @@
// Types and constants of the weighted harmonic window filter.
package whwf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 16;
  localparam int TERM_SHIFT = 31;
  localparam int TERM_W     = WEIGHT_W + TERM_SHIFT;
  localparam int SUM_W      = TERM_W + 3;
  localparam int STEP_W     = 6;
  localparam int BLEND_W    = 2 * WEIGHT_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_WEIGHTS = 5;

  localparam logic [STEP_W-1:0]   TERM_STEPS  = STEP_W'(TERM_W);
  localparam logic [STEP_W-1:0]   FINAL_STEPS = STEP_W'(SAMPLE_W);
  // Reciprocal of the sum reaches 2^SAMPLE_W once sum drops to 2^30.
  localparam logic [SUM_W-1:0]    SUM_SAT_LIMIT = SUM_W'(64'd1 << 30);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = {SAMPLE_W{1'b1}};
  localparam logic [WEIGHT_W-1:0] LAMBDA_ONE    = 16'd32768;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_4 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA   = 3'd6;

  localparam logic [WEIGHT_W-1:0] WEIGHT_THIRD = 16'd10923;
  localparam logic [WEIGHT_W-1:0] LAMBDA_HALF  = 16'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT,
    ST_TAP,
    ST_TAP_WAIT,
    ST_FINAL,
    ST_FINAL_WAIT,
    ST_STATS,
    ST_BLEND,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/whwf_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, shared by taps and reciprocal.
module whwf_div (
  input  logic                           clk,
  input  logic                           rst,
  input  whwf_pkg::div_req_t             req,
  input  logic [whwf_pkg::TERM_W-1:0]    num,
  input  logic [whwf_pkg::SUM_W-1:0]     den,
  input  logic [whwf_pkg::SUM_W-1:0]     rem_init,
  output whwf_pkg::div_stat_t            stat,
  output logic [whwf_pkg::TERM_W-1:0]    quo
);

  logic [whwf_pkg::STEP_W-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [whwf_pkg::SUM_W-1:0]  rem;
  logic [whwf_pkg::SUM_W-1:0]  den_reg;
  logic [whwf_pkg::TERM_W-1:0] num_sr;

  logic [whwf_pkg::SUM_W:0]    shifted;
  logic [whwf_pkg::SUM_W+1:0]  diff;
  logic                        qbit;
  logic [whwf_pkg::SUM_W-1:0]  rem_next;

  assign shifted  = {rem, num_sr[whwf_pkg::TERM_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, den_reg};
  assign qbit     = ~diff[whwf_pkg::SUM_W+1];
  assign rem_next = qbit ? diff[whwf_pkg::SUM_W-1:0] : shifted[whwf_pkg::SUM_W-1:0];

  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == whwf_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= rem_init;
      den_reg <= den;
      num_sr  <= num;
      quo     <= '0;
    end else if (busy) begin
      rem    <= rem_next;
      num_sr <= {num_sr[whwf_pkg::TERM_W-2:0], 1'b0};
      quo    <= {quo[whwf_pkg::TERM_W-2:0], qbit};
    end
  end

endmodule

@@ design/whwf_mac.sv @@
// Bit-serial blend of the two record peaks: lambda*noise + (1-lambda)*deviation.
module whwf_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [whwf_pkg::WEIGHT_W-1:0]  lam,
  input  logic [whwf_pkg::WEIGHT_W-1:0]  lam_c,
  input  logic [whwf_pkg::SAMPLE_W-1:0]  noise,
  input  logic [whwf_pkg::SAMPLE_W-1:0]  dev,
  output logic                           done,
  output logic [whwf_pkg::SAMPLE_W-1:0]  result
);

  localparam int CNT_W = $clog2(whwf_pkg::WEIGHT_W);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [whwf_pkg::WEIGHT_W-1:0] lam_sr;
  logic [whwf_pkg::WEIGHT_W-1:0] lamc_sr;
  logic [whwf_pkg::SAMPLE_W-1:0] noise_r;
  logic [whwf_pkg::SAMPLE_W-1:0] dev_r;
  logic [whwf_pkg::BLEND_W-1:0]  acc;
  logic [whwf_pkg::BLEND_W-1:0]  acc_next;

  // MSB first: double the running sum, add the selected multiplicands.
  assign acc_next = {acc[whwf_pkg::BLEND_W-2:0], 1'b0}
                  + whwf_pkg::BLEND_W'(lam_sr[whwf_pkg::WEIGHT_W-1] ? noise_r : '0)
                  + whwf_pkg::BLEND_W'(lamc_sr[whwf_pkg::WEIGHT_W-1] ? dev_r : '0);

  assign result = acc[whwf_pkg::SAMPLE_W+14:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= {CNT_W{1'b1}};
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lam_sr  <= lam;
      lamc_sr <= lam_c;
      noise_r <= noise;
      dev_r   <= dev;
      acc     <= '0;
    end else if (busy) begin
      lam_sr  <= {lam_sr[whwf_pkg::WEIGHT_W-2:0], 1'b0};
      lamc_sr <= {lamc_sr[whwf_pkg::WEIGHT_W-2:0], 1'b0};
      acc     <= acc_next;
    end
  end

endmodule

@@ design/weighted_harmonic_window_filter_core.sv @@
// A pass-through result passes the emit, stats and load states; an interior result takes
// one division per tap in the shared bit-serial divider, then the final reciprocal
// unless the sum saturates (a zero sample ends it early); the record's last result also
// waits for the serial blend. One item is in work at a time; the divider sets the
// throughput. Reset (rst, synchronous) restores the register defaults and clears
// the record count, both peaks and the output valid; the sample window is not cleared.
`include "assert_macros.svh"

module weighted_harmonic_window_filter_core #(
  parameter int MAX_TAPS = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [whwf_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic                            end_of_record,
  input  logic                            in_valid,
  output logic                            in_stall,
  output logic [whwf_pkg::SAMPLE_W-1:0]   filtered_out,
  output logic [whwf_pkg::SAMPLE_W-1:0]   noise_peak,
  output logic [whwf_pkg::SAMPLE_W-1:0]   deviation_peak,
  output logic [whwf_pkg::SAMPLE_W-1:0]   worse_of_two,
  output logic [whwf_pkg::SAMPLE_W-1:0]   criterion,
  output logic                            final_flag,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            cfg_write,
  input  logic [whwf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [whwf_pkg::WEIGHT_W-1:0]   cfg_data
);

  localparam int AGE_W   = $clog2(MAX_TAPS);
  localparam bit FIVE_OK = (MAX_TAPS >= 5);

  whwf_pkg::state_t state, state_next;

  // Configuration
  logic                          window_mode;
  logic [whwf_pkg::WEIGHT_W-1:0] weight [whwf_pkg::NUM_WEIGHTS];
  logic [whwf_pkg::WEIGHT_W-1:0] lambda_mix;

  // Record and item state
  logic [whwf_pkg::SAMPLE_W-1:0] win [MAX_TAPS];
  logic [2:0]                    record_count;
  logic [2:0]                    n_reg;
  logic [1:0]                    half_reg;
  logic                          last_reg;
  logic [2:0]                    cur_c;
  logic [2:0]                    end_c;
  logic [2:0]                    tap_j;
  logic [whwf_pkg::SUM_W-1:0]    sum;
  logic [whwf_pkg::SAMPLE_W-1:0] noisy;
  logic [whwf_pkg::SAMPLE_W-1:0] filt;
  logic [whwf_pkg::SAMPLE_W-1:0] prev_filt;
  logic [whwf_pkg::SAMPLE_W-1:0] noise_max;
  logic [whwf_pkg::SAMPLE_W-1:0] dev_max;

  // Combinational control
  logic                          accept;
  logic [1:0]                    half_now;
  logic                          n_ge_half;
  logic [2:0]                    age;
  logic                          interior;
  logic [2:0]                    j_last;
  logic [2:0]                    rd_age;
  logic [whwf_pkg::SAMPLE_W-1:0] rd_sample;
  logic                          out_free;
  logic                          is_final;
  logic                          sum_sat;
  logic                          load;
  logic                          mac_start;
  logic [whwf_pkg::SAMPLE_W-1:0] step_diff;
  logic [whwf_pkg::SAMPLE_W-1:0] dev_diff;
  logic [whwf_pkg::SAMPLE_W-1:0] noise_upd;
  logic [whwf_pkg::SAMPLE_W-1:0] dev_upd;
  logic [whwf_pkg::WEIGHT_W-1:0] lam_sat;
  logic [whwf_pkg::WEIGHT_W-1:0] lam_c;
  logic                          stats_clear;

  // Divider and blend connections
  whwf_pkg::div_req_t            div_req;
  whwf_pkg::div_stat_t           div_stat;
  logic [whwf_pkg::TERM_W-1:0]   div_num;
  logic [whwf_pkg::SUM_W-1:0]    div_den;
  logic [whwf_pkg::SUM_W-1:0]    div_rem_init;
  logic [whwf_pkg::TERM_W-1:0]   div_quo;
  logic                          mac_done;
  logic [whwf_pkg::SAMPLE_W-1:0] mac_result;

  assign accept    = in_valid && (state == whwf_pkg::ST_IDLE);
  assign in_stall  = (state != whwf_pkg::ST_IDLE);
  assign half_now  = (window_mode && FIVE_OK) ? 2'd2 : 2'd1;
  assign n_ge_half = (record_count >= {1'b0, half_now});
  assign age       = n_reg - cur_c;
  assign interior  = (cur_c >= {1'b0, half_reg}) && (age >= {1'b0, half_reg});
  assign j_last    = {half_reg, 1'b0};
  assign rd_sample = win[rd_age[AGE_W-1:0]];
  assign out_free  = !out_valid || !out_stall;
  assign is_final  = last_reg && (cur_c == end_c);
  assign sum_sat   = (sum <= whwf_pkg::SUM_SAT_LIMIT);
  assign step_diff = (filt > prev_filt) ? (filt - prev_filt) : (prev_filt - filt);
  assign dev_diff  = (filt > noisy) ? (filt - noisy) : (noisy - filt);
  // Peaks including the result in hand; the blend starts from these.
  assign noise_upd = ((cur_c != '0) && (step_diff > noise_max)) ? step_diff : noise_max;
  assign dev_upd   = (dev_diff > dev_max) ? dev_diff : dev_max;
  assign lam_sat   = (lambda_mix > whwf_pkg::LAMBDA_ONE) ? whwf_pkg::LAMBDA_ONE : lambda_mix;
  assign lam_c     = whwf_pkg::LAMBDA_ONE - lam_sat;
  assign stats_clear = (noise_peak == '0) && (deviation_peak == '0) &&
                       (worse_of_two == '0) && (criterion == '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      whwf_pkg::ST_IDLE: begin
        if (accept && (end_of_record || n_ge_half)) state_next = whwf_pkg::ST_EMIT;
      end
      whwf_pkg::ST_EMIT: begin
        state_next = interior ? whwf_pkg::ST_TAP : whwf_pkg::ST_STATS;
      end
      whwf_pkg::ST_TAP: begin
        state_next = (rd_sample == '0) ? whwf_pkg::ST_STATS : whwf_pkg::ST_TAP_WAIT;
      end
      whwf_pkg::ST_TAP_WAIT: begin
        if (div_stat.done)
          state_next = (tap_j == j_last) ? whwf_pkg::ST_FINAL : whwf_pkg::ST_TAP;
      end
      whwf_pkg::ST_FINAL: begin
        state_next = sum_sat ? whwf_pkg::ST_STATS : whwf_pkg::ST_FINAL_WAIT;
      end
      whwf_pkg::ST_FINAL_WAIT: begin
        if (div_stat.done) state_next = whwf_pkg::ST_STATS;
      end
      whwf_pkg::ST_STATS: begin
        state_next = is_final ? whwf_pkg::ST_BLEND : whwf_pkg::ST_LOAD;
      end
      whwf_pkg::ST_BLEND: begin
        if (mac_done) state_next = whwf_pkg::ST_LOAD;
      end
      whwf_pkg::ST_LOAD: begin
        if (out_free)
          state_next = (cur_c == end_c) ? whwf_pkg::ST_IDLE : whwf_pkg::ST_EMIT;
      end
      default: state_next = whwf_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    rd_age        = age;
    div_req.start = 1'b0;
    div_req.steps = whwf_pkg::TERM_STEPS;
    div_num       = {weight[tap_j], {whwf_pkg::TERM_SHIFT{1'b0}}};
    div_den       = whwf_pkg::SUM_W'(rd_sample);
    div_rem_init  = '0;
    mac_start     = 1'b0;
    load          = 1'b0;
    case (state)
      whwf_pkg::ST_TAP: begin
        rd_age        = j_last - tap_j;
        div_req.start = (rd_sample != '0);
      end
      whwf_pkg::ST_FINAL: begin
        div_req.start = !sum_sat;
        div_req.steps = whwf_pkg::FINAL_STEPS;
        div_num       = '0;
        div_den       = sum;
        div_rem_init  = whwf_pkg::SUM_SAT_LIMIT;
      end
      whwf_pkg::ST_STATS: mac_start = is_final;
      whwf_pkg::ST_LOAD:  load      = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= whwf_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode <= 1'b0;
      weight[0]   <= whwf_pkg::WEIGHT_THIRD;
      weight[1]   <= whwf_pkg::WEIGHT_THIRD;
      weight[2]   <= whwf_pkg::WEIGHT_THIRD;
      weight[3]   <= '0;
      weight[4]   <= '0;
      lambda_mix  <= whwf_pkg::LAMBDA_HALF;
    end else if (cfg_write) begin
      case (cfg_index)
        whwf_pkg::CFG_MODE:     window_mode <= cfg_data[0];
        whwf_pkg::CFG_WEIGHT_0: weight[0]   <= cfg_data;
        whwf_pkg::CFG_WEIGHT_1: weight[1]   <= cfg_data;
        whwf_pkg::CFG_WEIGHT_2: weight[2]   <= cfg_data;
        whwf_pkg::CFG_WEIGHT_3: weight[3]   <= cfg_data;
        whwf_pkg::CFG_WEIGHT_4: weight[4]   <= cfg_data;
        whwf_pkg::CFG_LAMBDA:   lambda_mix  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Record control and running peaks
  always_ff @(posedge clk) begin
    if (rst) begin
      record_count <= '0;
      noise_max    <= '0;
      dev_max      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        if (end_of_record)          record_count <= '0;
        else if (record_count != 3'd7) record_count <= record_count + 1'b1;
      end
      if (state == whwf_pkg::ST_STATS) begin
        noise_max <= noise_upd;
        dev_max   <= dev_upd;
      end
      if (load && is_final) begin
        noise_max <= '0;
        dev_max   <= '0;
      end
      if (load)          out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Window, item bookkeeping and filter value
  always_ff @(posedge clk) begin
    if (accept) begin
      win[0] <= sample_in;
      for (int i = 1; i < MAX_TAPS; i++) win[i] <= win[i-1];
      n_reg    <= record_count;
      half_reg <= half_now;
      last_reg <= end_of_record;
      end_c    <= end_of_record ? record_count : (record_count - {1'b0, half_now});
      cur_c    <= (end_of_record && !n_ge_half) ? 3'd0 : (record_count - {1'b0, half_now});
    end
    case (state)
      whwf_pkg::ST_EMIT: begin
        noisy <= rd_sample;
        tap_j <= '0;
        sum   <= '0;
        if (!interior) filt <= rd_sample;
      end
      whwf_pkg::ST_TAP: begin
        if (rd_sample == '0) filt <= '0;
      end
      whwf_pkg::ST_TAP_WAIT: begin
        if (div_stat.done) begin
          sum   <= sum + whwf_pkg::SUM_W'(div_quo);
          tap_j <= tap_j + 1'b1;
        end
      end
      whwf_pkg::ST_FINAL: begin
        if (sum_sat) filt <= whwf_pkg::SAMPLE_MAX;
      end
      whwf_pkg::ST_FINAL_WAIT: begin
        if (div_stat.done) filt <= div_quo[whwf_pkg::SAMPLE_W-1:0];
      end
      // Drop the previous value at record end.
      whwf_pkg::ST_STATS: prev_filt <= is_final ? '0 : filt;
      whwf_pkg::ST_LOAD: begin
        if (out_free && (cur_c != end_c)) cur_c <= cur_c + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      filtered_out <= filt;
      final_flag   <= is_final;
      if (is_final) begin
        noise_peak     <= noise_max;
        deviation_peak <= dev_max;
        worse_of_two   <= (noise_max > dev_max) ? noise_max : dev_max;
        criterion      <= mac_result;
      end else begin
        noise_peak     <= '0;
        deviation_peak <= '0;
        worse_of_two   <= '0;
        criterion      <= '0;
      end
    end
  end

  whwf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .num      (div_num),
    .den      (div_den),
    .rem_init (div_rem_init),
    .stat     (div_stat),
    .quo      (div_quo)
  );

  whwf_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (mac_start),
    .lam    (lam_sat),
    .lam_c  (lam_c),
    .noise  (noise_upd),
    .dev    (dev_upd),
    .done   (mac_done),
    .result (mac_result)
  );

  `ASSERT_IMPL(a_div_start_idle, div_req.start, !div_stat.busy)
  `ASSERT_NEXT(a_count_clear_on_last, accept && end_of_record, record_count == '0)
  `ASSERT_IMPL(a_tap_in_window, state == whwf_pkg::ST_TAP, tap_j <= j_last)
  `ASSERT_IMPL(a_stats_only_final, out_valid && !final_flag, stats_clear)

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the weighted harmonic window filter core.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_TAPS       = 5;
  localparam int COUNT_CEILING  = 7;
  localparam int GAP_MAX        = 13;
  localparam int SETTLE_CYCLES  = 400;
  localparam int HOLDOFF_CYCLES = 1500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT   = 10;

  typedef logic [whwf_pkg::SAMPLE_W-1:0] sample_t;
  typedef bit [whwf_pkg::WEIGHT_W-1:0] weight_set_t [whwf_pkg::NUM_WEIGHTS];

  typedef struct packed {
    sample_t filtered;
    sample_t noise;
    sample_t deviation;
    sample_t worse;
    sample_t crit;
    logic    last;
  } filter_result_t;

  logic                           clk;
  logic                           rst;
  sample_t                        sample_in;
  logic                           end_of_record;
  logic                           in_valid;
  logic                           in_stall;
  sample_t                        filtered_out;
  sample_t                        noise_peak;
  sample_t                        deviation_peak;
  sample_t                        worse_of_two;
  sample_t                        criterion;
  logic                           final_flag;
  logic                           out_valid;
  logic                           out_stall;
  logic                           cfg_write;
  logic [whwf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [whwf_pkg::WEIGHT_W-1:0]  cfg_data;

  // Filter mirror: registers and record state.
  bit                          five_taps;
  weight_set_t                 tap_weight;
  bit [whwf_pkg::WEIGHT_W-1:0] lambda_reg;
  bit [whwf_pkg::SAMPLE_W-1:0] tap_line [MAX_TAPS];
  int                          record_len;
  bit [whwf_pkg::SAMPLE_W-1:0] last_filtered;
  bit [whwf_pkg::SAMPLE_W-1:0] step_peak;
  bit [whwf_pkg::SAMPLE_W-1:0] dev_peak;

  filter_result_t pending_results[$];
  int             mismatches;
  int             send_gap_max;
  int             recv_gap_max;
  bit             hold_off;
  int             quiet_cycles;

  weighted_harmonic_window_filter_core #(.MAX_TAPS(MAX_TAPS)) dut (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic sample_t abs_gap(sample_t a, sample_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void queue_result(filter_result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Filter the sample at the given age; interior ones use the newest 2*half+1 samples.
  function automatic filter_result_t filter_one(int pos, int age, int half, bit interior);
    filter_result_t r;
    sample_t        noisy;
    sample_t        f;
    sample_t        s;
    bit [63:0]      recip_sum;
    bit [63:0]      quot;
    bit             zero_seen;
    noisy = tap_line[MAX_TAPS - 1 - age];
    f = noisy;
    if (interior) begin
      recip_sum = '0;
      zero_seen = 1'b0;
      for (int j = 0; j < 2 * half + 1; j++) begin
        s = tap_line[MAX_TAPS - 1 - (2 * half - j)];
        if (s == '0) zero_seen = 1'b1;
        else recip_sum += (64'(tap_weight[j]) << whwf_pkg::TERM_SHIFT) / 64'(s);
      end
      if (zero_seen) begin
        f = '0;
      end else if (recip_sum == '0) begin
        f = whwf_pkg::SAMPLE_MAX;
      end else begin
        quot = (64'd1 << (whwf_pkg::SAMPLE_W + 30)) / recip_sum;
        f = (quot > 64'(whwf_pkg::SAMPLE_MAX)) ? whwf_pkg::SAMPLE_MAX
                                                : quot[whwf_pkg::SAMPLE_W-1:0];
      end
    end
    if (pos > 0 && abs_gap(f, last_filtered) > step_peak) step_peak = abs_gap(f, last_filtered);
    if (abs_gap(f, noisy) > dev_peak) dev_peak = abs_gap(f, noisy);
    last_filtered = f;
    r = '0;
    r.filtered = f;
    return r;
  endfunction

  function automatic bit [whwf_pkg::WEIGHT_W-1:0] draw_q15();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return whwf_pkg::LAMBDA_ONE;
      2: return '1;
      3: return whwf_pkg::WEIGHT_W'($urandom_range(64, 1));
      4: return whwf_pkg::WEIGHT_W'($urandom());
      default: return whwf_pkg::WEIGHT_W'($urandom_range(32768, 0));
    endcase
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(31, 0))
      0: return '0;
      1: return whwf_pkg::SAMPLE_MAX;
      2, 3: return sample_t'($urandom_range(255, 1));
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Drop the input offer, then wait for the core to drain.
  task automatic wait_settled();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every register in turn once the core has gone quiet.
  task automatic load_registers(bit mode, weight_set_t weights,
                                bit [whwf_pkg::WEIGHT_W-1:0] lam);
    wait_settled();
    cfg_write <= 1'b1;
    cfg_index <= whwf_pkg::CFG_MODE;
    cfg_data  <= whwf_pkg::WEIGHT_W'(mode);
    @(posedge clk);
    for (int i = 0; i < whwf_pkg::NUM_WEIGHTS; i++) begin
      cfg_index <= whwf_pkg::CFG_WEIGHT_0 + whwf_pkg::CFG_IDX_W'(i);
      cfg_data  <= weights[i];
      @(posedge clk);
    end
    cfg_index <= whwf_pkg::CFG_LAMBDA;
    cfg_data  <= lam;
    @(posedge clk);
    cfg_write <= 1'b0;
    five_taps  = mode;
    tap_weight = weights;
    lambda_reg = lam;
  endtask

  // Offer one sample, wait for its transfer, then queue the results it causes.
  task automatic send_sample(sample_t smp, bit eor);
    filter_result_t              tail;
    int                          gap;
    int                          half;
    int                          n;
    int                          pos;
    bit [whwf_pkg::WEIGHT_W-1:0] lam;
    bit [33:0]                   blend;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_in     <= smp;
    end_of_record <= eor;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);

    half = (five_taps && MAX_TAPS >= 5) ? 2 : 1;
    n = record_len;
    for (int i = 0; i < MAX_TAPS - 1; i++) tap_line[i] = tap_line[i + 1];
    tap_line[MAX_TAPS - 1] = smp;
    if (!eor) begin
      if (n >= half) queue_result(filter_one(n - half, half, half, n >= 2 * half));
      record_len = (n < COUNT_CEILING) ? n + 1 : COUNT_CEILING;
    end else begin
      // Flush the held-back samples; the newest one always passes through.
      pos = (n >= half) ? n - half : 0;
      while (pos < n) begin
        queue_result(filter_one(pos, n - pos, half, pos >= half && n - pos >= half));
        pos++;
      end
      tail = filter_one(n, 0, half, 1'b0);
      lam = (lambda_reg > whwf_pkg::LAMBDA_ONE) ? whwf_pkg::LAMBDA_ONE : lambda_reg;
      blend = 34'(lam) * 34'(step_peak) + 34'(whwf_pkg::LAMBDA_ONE - lam) * 34'(dev_peak);
      tail.noise     = step_peak;
      tail.deviation = dev_peak;
      tail.worse     = (step_peak > dev_peak) ? step_peak : dev_peak;
      tail.crit      = blend[whwf_pkg::SAMPLE_W+14:15];
      tail.last      = 1'b1;
      queue_result(tail);
      record_len    = 0;
      last_filtered = '0;
      step_peak     = '0;
      dev_peak      = '0;
    end
  endtask

  task automatic run_three_tap_edges();
    send_sample(16'h4000, 1'b0);
    send_sample(whwf_pkg::SAMPLE_MAX, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h8000, 1'b1);
    // single-sample record, then a two-sample record
    send_sample(16'h1234, 1'b1);
    send_sample(whwf_pkg::SAMPLE_MAX, 1'b0);
    send_sample(16'h0000, 1'b1);
  endtask

  task automatic run_five_tap_long_record();
    load_registers(1'b1, '{16'd0, 16'hFFFF, whwf_pkg::LAMBDA_ONE, 16'd1, 16'd12000},
                   16'hFFFF);
    // longer than the count ceiling so the count saturates
    for (int k = 0; k < 8; k++)
      send_sample((k == 3) ? whwf_pkg::SAMPLE_MAX : sample_t'($urandom_range(65535, 1)),
                  k == 7);
  endtask

  task automatic run_mode_switch_in_record();
    weight_set_t w;
    w = '{16'd6554, 16'd6554, 16'd6554, 16'd6554, 16'd6554};
    load_registers(1'b1, w, whwf_pkg::LAMBDA_ONE);
    for (int k = 0; k < 3; k++) send_sample(sample_t'($urandom_range(65535, 1)), 1'b0);
    load_registers(1'b0, w, whwf_pkg::LAMBDA_ONE);
    for (int k = 0; k < 3; k++) send_sample(sample_t'($urandom_range(65535, 1)), k == 2);
  endtask

  task automatic run_zero_weights();
    load_registers(1'b0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 16'd0);
    send_sample(16'h1000, 1'b0);
    send_sample(16'h2000, 1'b0);
    send_sample(16'h3000, 1'b1);
  endtask

  task automatic run_output_holdoff();
    load_registers(1'b0, '{whwf_pkg::WEIGHT_THIRD, whwf_pkg::WEIGHT_THIRD,
                           whwf_pkg::WEIGHT_THIRD, 16'd0, 16'd0},
                   whwf_pkg::LAMBDA_HALF);
    send_gap_max = 0;
    recv_gap_max = 0;
    // hold the output off while samples keep coming so the input backs up
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (int k = 0; k < 20; k++) send_sample(draw_sample(), k == 19);
    send_gap_max = GAP_MAX;
    recv_gap_max = GAP_MAX;
  endtask

  task automatic run_random_records();
    weight_set_t w;
    int          len;
    int          left;
    for (int phase = 0; phase < 7; phase++) begin
      for (int i = 0; i < whwf_pkg::NUM_WEIGHTS; i++) w[i] = draw_q15();
      load_registers(1'($urandom_range(1, 0)), w, draw_q15());
      case (phase % 4)
        0: begin send_gap_max = GAP_MAX; recv_gap_max = GAP_MAX; end
        1: begin send_gap_max = 0;       recv_gap_max = 0;       end
        2: begin send_gap_max = 0;       recv_gap_max = GAP_MAX; end
        default: begin send_gap_max = GAP_MAX; recv_gap_max = 0; end
      endcase
      left = 60;
      while (left > 0) begin
        len = ($urandom_range(7, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
        if (len > left) len = left;
        for (int k = 1; k <= len; k++) send_sample(draw_sample(), k == len);
        left -= len;
      end
    end
    send_gap_max = GAP_MAX;
    recv_gap_max = GAP_MAX;
  endtask

  initial begin : result_monitor
    filter_result_t want;
    int             stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result at %0t: f=%h final=%b", $time, filtered_out, final_flag);
        end else begin
          want = pending_results.pop_front();
          if (filtered_out !== want.filtered || noise_peak !== want.noise ||
              deviation_peak !== want.deviation || worse_of_two !== want.worse ||
              criterion !== want.crit || final_flag !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("mismatch at %0t: expected f=%h n=%h d=%h w=%h c=%h last=%b", $time,
                       want.filtered, want.noise, want.deviation, want.worse, want.crit,
                       want.last);
              $display("                 actual   f=%h n=%h d=%h w=%h c=%h last=%b",
                       filtered_out, noise_peak, deviation_peak, worse_of_two, criterion,
                       final_flag);
            end
          end
        end
        stall_left = $urandom_range(recv_gap_max, 0);
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Abort when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("weighted_harmonic_window_filter_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    sample_in     <= '0;
    end_of_record <= 1'b0;
    cfg_write     <= 1'b0;
    cfg_index     <= whwf_pkg::CFG_MODE;
    cfg_data      <= '0;
    five_taps     = 1'b0;
    tap_weight    = '{whwf_pkg::WEIGHT_THIRD, whwf_pkg::WEIGHT_THIRD,
                      whwf_pkg::WEIGHT_THIRD, 16'd0, 16'd0};
    lambda_reg    = whwf_pkg::LAMBDA_HALF;
    send_gap_max  = GAP_MAX;
    recv_gap_max  = GAP_MAX;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_three_tap_edges();
    run_five_tap_long_record();
    run_mode_switch_in_record();
    run_zero_weights();
    run_output_holdoff();
    run_random_records();

    wait_settled();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("weighted_harmonic_window_filter_core regression: pass");
    end else begin
      $display("weighted_harmonic_window_filter_core regression: fail");
    end
    $finish;
  end

endmodule
